// ===== rtl/utsb_pkg.sv =====
package utsb_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned NibW    = 4;
  localparam int unsigned CountW  = 6;
  localparam int unsigned SlotW   = 5;
  localparam int unsigned NumNibs = 32;
  localparam int unsigned NumBytes = 16;
  localparam int unsigned ByteCntW = 4;

  localparam logic [CountW-1:0] LenDashed = CountW'(36);
  localparam logic [CountW-1:0] LenPlain  = CountW'(32);
  localparam logic [CountW-1:0] CountMax  = CountW'(63);

  // dashed-form separator positions
  localparam logic [CountW-1:0] SepA = CountW'(8);
  localparam logic [CountW-1:0] SepB = CountW'(13);
  localparam logic [CountW-1:0] SepC = CountW'(18);
  localparam logic [CountW-1:0] SepD = CountW'(23);

  typedef struct packed {
    logic             used;
    logic [SlotW-1:0] slot;
  } slot_t;

  typedef struct packed {
    logic            ok;
    logic [NibW-1:0] nib;
  } hex_t;

  function automatic hex_t decode_hex(input logic [CharW-1:0] ch);
    hex_t r;
    r.ok  = 1'b1;
    r.nib = '0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      r.nib = NibW'(ch - 8'h30);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      r.nib = NibW'(ch - 8'h37);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      r.nib = NibW'(ch - 8'h57);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // text position -> nibble slot in time-swapped order
  function automatic slot_t map_slot(input logic [CountW-1:0] pos, input logic dashed);
    slot_t            r;
    logic [CountW-1:0] d;
    r.used = 1'b1;
    d      = pos;
    if (!dashed) begin
      r.used = (pos < LenPlain);
    end else if (pos >= LenDashed || pos == SepA || pos == SepB ||
                 pos == SepC || pos == SepD) begin
      r.used = 1'b0;
    end else if (pos < SepA) begin
      d = pos;
    end else if (pos < SepB) begin
      d = pos - CountW'(1);
    end else if (pos < SepC) begin
      d = pos - CountW'(2);
    end else if (pos < SepD) begin
      d = pos - CountW'(3);
    end else begin
      d = pos - CountW'(4);
    end
    if (d < CountW'(8)) begin
      r.slot = SlotW'(d + CountW'(8));
    end else if (d < CountW'(12)) begin
      r.slot = SlotW'(d - CountW'(4));
    end else if (d < CountW'(16)) begin
      r.slot = SlotW'(d - CountW'(12));
    end else begin
      r.slot = SlotW'(d);
    end
    return r;
  endfunction

endpackage

// ===== rtl/utsb_if.sv =====
interface utsb_char_if;
  import utsb_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             last_char;
  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface utsb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       bad_input;
  modport source (output valid, output data_byte, output last_byte, output bad_input,
                  input ready);
  modport sink   (input valid, input data_byte, input last_byte, input bad_input,
                  output ready);
endinterface

interface utsb_cfg_if;
  logic valid;
  logic ready;
  logic dashed_format;
  modport source (output valid, output dashed_format, input ready);
  modport sink   (input valid, input dashed_format, output ready);
endinterface

// ===== rtl/uuid_text_to_swapped_binary.sv =====
// UUID text to time-swapped binary. Characters come in one word per cycle on
// char_i, last_char set on the final one. cfg_i.dashed_format (reset 1)
// picks the 36-character dashed form (separator positions 8, 13, 18, 23 are
// skipped unchecked) or the 32-digit plain form. On the last character the
// block either emits 16 bytes on byte_o (time-high, time-mid, time-low, then
// the rest; last_byte on the 16th) or one error word (data 0, last_byte 1,
// bad_input 1) if the length is wrong or a used character is not hex.
// Rate: one character per cycle. Used hex digits are decoded into a
// 32-entry nibble file in the cycle they are accepted; the last character
// snapshots the whole file into a 16-byte output shift register, so the
// next string streams in while the bytes drain. Output moves one byte per
// cycle when byte_o.ready is high, so a last character waits (ready low)
// only while the previous run still has bytes to deliver beyond the one
// going out. Configuration is taken at any time (cfg_i.ready is tied high).
module uuid_text_to_swapped_binary (
  input logic  clk_i,
  input logic  rst_ni,
  utsb_char_if.sink   char_i,
  utsb_cfg_if.sink    cfg_i,
  utsb_byte_if.source byte_o
);
  import utsb_pkg::*;

  logic                dashed_q;
  logic [CountW-1:0]   count_q, count_d;
  logic                fault_q, fault_d;
  logic [NibW-1:0]     nib_q [NumNibs];

  logic                busy_q, busy_d;
  logic                err_q, err_d;
  logic [ByteCntW-1:0] cnt_q, cnt_d;
  logic [8*NumBytes-1:0] buf_q, buf_d;

  logic              acc;
  logic              out_fire;
  logic              out_final;
  logic              buf_free;
  hex_t              hx;
  slot_t             sl;
  logic              bad_now;
  logic              len_bad;
  logic [CountW-1:0] exp_last;
  logic [8*NumBytes-1:0] snap;

  // config: dashed_format register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dashed_q <= 1'b1;
    end else if (cfg_i.valid) begin
      dashed_q <= cfg_i.dashed_format;
    end
  end

  // output handshake
  assign out_fire  = byte_o.valid && byte_o.ready;
  assign out_final = err_q || (cnt_q == ByteCntW'(NumBytes - 1));
  assign buf_free  = !busy_q || (out_fire && out_final);

  // only a last character needs the output buffer
  assign char_i.ready = !char_i.last_char || buf_free;
  assign acc          = char_i.valid && char_i.ready;

  // per-character decode
  always_comb begin
    hx       = decode_hex(char_i.char_code);
    sl       = map_slot(count_q, dashed_q);
    bad_now  = sl.used && !hx.ok;
    exp_last = dashed_q ? (LenDashed - CountW'(1)) : (LenPlain - CountW'(1));
    len_bad  = (count_q != exp_last);
  end

  // nibble file, no reset: entries are defined once written
  always_ff @(posedge clk_i) begin
    if (acc && sl.used && hx.ok) begin
      nib_q[sl.slot] <= hx.nib;
    end
  end

  // snapshot including the nibble landing this cycle; byte 0 at the top
  always_comb begin
    for (int j = 0; j < NumNibs; j++) begin
      if (sl.used && hx.ok && (sl.slot == SlotW'(j))) begin
        snap[8*NumBytes-1-NibW*j -: NibW] = hx.nib;
      end else begin
        snap[8*NumBytes-1-NibW*j -: NibW] = nib_q[SlotW'(j)];
      end
    end
  end

  // string tracking
  always_comb begin
    count_d = count_q;
    fault_d = fault_q;
    if (acc) begin
      if (char_i.last_char) begin
        count_d = '0;
        fault_d = 1'b0;
      end else begin
        if (count_q != CountMax) count_d = count_q + CountW'(1);
        if (bad_now) fault_d = 1'b1;
      end
    end
  end

  // output buffer
  always_comb begin
    busy_d = busy_q;
    err_d  = err_q;
    cnt_d  = cnt_q;
    buf_d  = buf_q;
    if (out_fire) begin
      if (out_final) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + ByteCntW'(1);
        buf_d = {buf_q[8*NumBytes-9:0], 8'h00};
      end
    end
    if (acc && char_i.last_char) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      err_d  = len_bad || fault_q || bad_now;
      buf_d  = snap;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      fault_q <= 1'b0;
      busy_q  <= 1'b0;
      err_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      count_q <= count_d;
      fault_q <= fault_d;
      busy_q  <= busy_d;
      err_q   <= err_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  assign byte_o.valid     = busy_q;
  assign byte_o.data_byte = err_q ? 8'h00 : buf_q[8*NumBytes-1 -: 8];
  assign byte_o.last_byte = out_final;
  assign byte_o.bad_input = err_q;

  // checks
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_o.valid && byte_o.bad_input |-> byte_o.last_byte && (byte_o.data_byte == 8'h00))
    else $error("error word malformed");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && char_i.last_char |-> !busy_q || (out_fire && out_final))
    else $error("last character taken while bytes pending");

  a_run_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && char_i.last_char |=> busy_q && (cnt_q == '0))
    else $error("run did not start after last character");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && err_q |-> (cnt_q == '0))
    else $error("error run longer than one word");

endmodule

// ===== bench/tb_uuid_text_to_swapped_binary.sv =====
`timescale 1ns / 100ps

module tb_uuid_text_to_swapped_binary;
  import utsb_pkg::*;

  localparam int unsigned HalfPeriod    = 10;
  localparam int unsigned ResetCycles   = 4;
  localparam int unsigned RandItems     = 250;   // characters in the random part
  localparam int unsigned HoldAt        = 60;    // random-part point for the long sink stall
  localparam int unsigned CalmFrom      = 200;   // no idling from here on
  localparam int unsigned HoldCycles    = 240;
  localparam int unsigned SettleCycles  = 4;     // lets the char path settle before a format write
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned MaxReports    = 10;

  // ASCII codes
  localparam bit [7:0] ChZero = 8'h30;
  localparam bit [7:0] ChNine = 8'h39;
  localparam bit [7:0] ChUpA  = 8'h41;
  localparam bit [7:0] ChUpF  = 8'h46;
  localparam bit [7:0] ChLowA = 8'h61;
  localparam bit [7:0] ChLowF = 8'h66;
  localparam bit [7:0] ChDash = 8'h2d;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } uuid_word_t;

  // how a directed row's output words are known
  typedef enum {CHK_MODEL, CHK_ERROR, CHK_FILL} check_e;

  // random string shapes
  typedef enum {SHAPE_CLEAN, SHAPE_SPOT, SHAPE_SHORT, SHAPE_LONG, SHAPE_NOISE} shape_e;

  typedef struct {
    bit       dashed;
    string    text;
    int       patch_at;   // position overwritten with patch_val, -1 for none
    bit [7:0] patch_val;
    check_e   chk;
    bit [7:0] fill;       // every byte of a CHK_FILL row
  } dir_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  utsb_char_if char_if ();
  utsb_cfg_if  cfg_if ();
  utsb_byte_if byte_if ();

  uuid_text_to_swapped_binary DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_if),
    .cfg_i  (cfg_if),
    .byte_o (byte_if)
  );

  always begin
    #(HalfPeriod) clk_i = 1'b1;
    #(HalfPeriod) clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor state: format bit, text position, nibble file, digit fault
  // ---------------------------------------------------------------------
  bit               fmt_dashed  = 1'b1;
  bit [CountW-1:0]  text_pos    = '0;
  bit [NibW-1:0]    nib_file [NumNibs];
  bit               digit_fault = 1'b0;

  uuid_word_t bytes_due [$];   // words still owed by the block, oldest first
  uuid_word_t fresh [$];       // words caused by the character just taken
  bit [7:0]   txt [$];         // random string being sent

  int unsigned mismatches   = 0;
  int unsigned used_items   = 0;
  int unsigned stuck_cycles = 0;
  bit          hold_req     = 1'b0;
  bit          hold_done    = 1'b0;
  bit          calm         = 1'b0;
  bit          tx_choppy    = 1'b0;
  bit          rx_choppy    = 1'b1;

  function automatic uuid_word_t mk_word(bit [7:0] d, bit l, bit b);
    uuid_word_t w;
    w.data = d;
    w.last = l;
    w.bad  = b;
    return w;
  endfunction

  // bit 4 set: not a hex digit
  function automatic bit [4:0] hex_nibble(bit [7:0] c);
    if (c >= ChZero && c <= ChNine) return {1'b0, 4'(c - ChZero)};
    if (c >= ChUpA && c <= ChUpF) return {1'b0, 4'(c - ChUpA + 8'd10)};
    if (c >= ChLowA && c <= ChLowF) return {1'b0, 4'(c - ChLowA + 8'd10)};
    return 5'h10;
  endfunction

  // Text position -> nibble slot in time-swapped order, -1 when the
  // character is a separator or lies past the expected length.
  function automatic int text_slot(bit [CountW-1:0] pos, bit dashed);
    int p;
    int d;
    p = int'(pos);
    if (!dashed) begin
      d = (p < int'(LenPlain)) ? p : -1;
    end else if (p >= int'(LenDashed) || p == int'(SepA) || p == int'(SepB) ||
                 p == int'(SepC) || p == int'(SepD)) begin
      d = -1;
    end else begin
      d = p - int'(p > int'(SepA)) - int'(p > int'(SepB)) - int'(p > int'(SepC))
            - int'(p > int'(SepD));
    end
    if (d < 0) return -1;
    if (d < 8) return d + 8;     // time-low goes after time-mid/high
    if (d < 12) return d - 4;    // time-mid
    if (d < 16) return d - 12;   // time-high first
    return d;
  endfunction

  // Advance the predictor by one character; output words land in fresh.
  function automatic int predict_char(bit [7:0] c, bit last);
    int       slot;
    int       pos;
    bit [4:0] h;
    slot = text_slot(text_pos, fmt_dashed);
    pos  = int'(text_pos);
    fresh.delete();
    if (slot >= 0) begin
      h = hex_nibble(c);
      if (h[4]) begin
        digit_fault = 1'b1;
      end else begin
        nib_file[SlotW'(slot)] = h[3:0];
      end
    end
    if (text_pos != CountMax) text_pos = text_pos + CountW'(1);
    if (last) begin
      if (pos + 1 != int'(fmt_dashed ? LenDashed : LenPlain) || digit_fault) begin
        fresh.push_back(mk_word(8'h00, 1'b1, 1'b1));
      end else begin
        for (int k = 0; k < int'(NumBytes); k++) begin
          fresh.push_back(mk_word({nib_file[SlotW'(2*k)], nib_file[SlotW'(2*k+1)]},
                                  k == int'(NumBytes) - 1, 1'b0));
        end
      end
      text_pos    = '0;
      digit_fault = 1'b0;
    end
    return slot;
  endfunction

  function automatic bit [7:0] rand_hex();
    int unsigned v;
    v = $urandom_range(0, 15);
    if (v < 10) return ChZero + 8'(v);
    return ($urandom_range(0, 1) ? ChLowA : ChUpA) + 8'(v - 10);
  endfunction

  // Offer one character, wait for the handshake, then book the words it owes.
  // Typed rows replace the predicted words with hand-written ones.
  task automatic send_char(bit [7:0] c, bit last, check_e chk, bit [7:0] fill);
    if (!calm && tx_choppy && $urandom_range(0, 5) == 0) begin
      char_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    char_if.valid     <= 1'b1;
    char_if.char_code <= c;
    char_if.last_char <= last;
    do @(posedge clk_i); while (!char_if.ready);
    void'(predict_char(c, last));
    if (last && chk == CHK_ERROR) begin
      fresh.delete();
      fresh.push_back(mk_word(8'h00, 1'b1, 1'b1));
    end else if (last && chk == CHK_FILL) begin
      fresh.delete();
      for (int k = 0; k < int'(NumBytes); k++) begin
        fresh.push_back(mk_word(fill, k == int'(NumBytes) - 1, 1'b0));
      end
    end
    foreach (fresh[i]) bytes_due.push_back(fresh[i]);
    used_items++;
  endtask

  // Format write: only with the block drained and the char path settled.
  task automatic set_format(bit dashed);
    char_if.valid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_if.valid         <= 1'b1;
    cfg_if.dashed_format <= dashed;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    fmt_dashed = dashed;
  endtask

  // Random string: mostly well-formed text in the current format with random
  // digits and case, the rest spoiled, cut short, overlong or pure noise.
  task automatic build_text();
    int     len;
    int     cut;
    shape_e shape;
    int     roll;
    txt.delete();
    len = fmt_dashed ? int'(LenDashed) : int'(LenPlain);
    for (int p = 0; p < len; p++) begin
      if (fmt_dashed && (p == int'(SepA) || p == int'(SepB) || p == int'(SepC) ||
                         p == int'(SepD))) begin
        // separators are unchecked, so any byte may stand there
        txt.push_back($urandom_range(0, 3) != 0 ? ChDash : 8'($urandom_range(0, 255)));
      end else begin
        txt.push_back(rand_hex());
      end
    end
    roll  = $urandom_range(0, 9);
    shape = (roll < 6) ? SHAPE_CLEAN : shape_e'(roll - 5);
    case (shape)
      SHAPE_SPOT: begin
        txt[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
      end
      SHAPE_SHORT: begin
        cut = $urandom_range(1, len - 1);
        while (txt.size() > cut) void'(txt.pop_back());
      end
      SHAPE_LONG: begin
        // up to 70 characters, well past the saturating count
        repeat ($urandom_range(1, 34)) txt.push_back(8'($urandom_range(0, 255)));
      end
      SHAPE_NOISE: begin
        txt.delete();
        repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Output side: random stall bursts, one long hold-off, none when calm
  // ---------------------------------------------------------------------
  initial begin : sink_side
    byte_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 63) == 0) rx_choppy = !rx_choppy;
      if (hold_req) begin
        // long stall so the char side backs up behind a full output
        hold_req = 1'b0;
        byte_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        byte_if.ready <= 1'b1;
      end else if (rx_choppy && !calm && $urandom_range(0, 5) == 0) begin
        byte_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        byte_if.ready <= 1'b1;
      end else begin
        byte_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Word checker: each accepted word against the oldest one owed
  // ---------------------------------------------------------------------
  task automatic report_word(string what, uuid_word_t want, uuid_word_t seen);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("%0t: %s: exp data %02h last %0b bad %0b, got data %02h last %0b bad %0b",
               $time, what, want.data, want.last, want.bad,
               seen.data, seen.last, seen.bad);
    end
  endtask

  always @(posedge clk_i) begin : check_words
    uuid_word_t seen;
    uuid_word_t want;
    if (rst_ni && byte_if.valid && byte_if.ready) begin
      seen = mk_word(byte_if.data_byte, byte_if.last_byte, byte_if.bad_input);
      if (bytes_due.size() == 0) begin
        report_word("word with nothing owed", '0, seen);
      end else begin
        want = bytes_due.pop_front();
        if (seen.data !== want.data || seen.last !== want.last || seen.bad !== want.bad) begin
          report_word("word mismatch", want, seen);
        end
      end
    end
  end

  // Watchdog: cycles in a row with no handshake on any channel.
  always @(posedge clk_i) begin
    if ((char_if.valid && char_if.ready) || (byte_if.valid && byte_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == WatchdogLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus: directed strings, then random strings
  // ---------------------------------------------------------------------
  dir_row_t dir_tab [6];

  initial begin : stimulus
    string    s;
    bit [7:0] c;
    int       n;

    char_if.valid        <= 1'b0;
    char_if.char_code    <= '0;
    char_if.last_char    <= 1'b0;
    cfg_if.valid         <= 1'b0;
    cfg_if.dashed_format <= 1'b1;

    // reset value of the format is dashed: first row runs without a write;
    // separator at 13 carries 0xff and must be skipped unchecked
    dir_tab[0] = '{1'b1, "00000000-0000-0000-0000-000000000000", 13, 8'hff, CHK_FILL, 8'h00};
    // swap order: time-high, time-mid, time-low, rest
    dir_tab[1] = '{1'b1, "01234567-89AB-cdef-0123-456789abcdef", -1, 8'h00, CHK_MODEL, 8'h00};
    // one character alone: wrong length
    dir_tab[2] = '{1'b1, "z", -1, 8'h00, CHK_ERROR, 8'h00};
    // plain form, mixed case, all ones
    dir_tab[3] = '{1'b0, "ffffffffFFFFFFFFffffffffFFFFFFFF", -1, 8'h00, CHK_FILL, 8'hff};
    // non-hex on the last character itself
    dir_tab[4] = '{1'b0, "0123456789abcdef0123456789abcdef", 31, 8'h00, CHK_ERROR, 8'h00};
    // dashed form one short
    dir_tab[5] = '{1'b1, "00000000-0000-0000-0000-00000000000", -1, 8'h00, CHK_ERROR, 8'h00};

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < $size(dir_tab); r++) begin
      if (dir_tab[r].dashed != fmt_dashed) set_format(dir_tab[r].dashed);
      tx_choppy = ($urandom_range(0, 2) != 0);
      s = dir_tab[r].text;
      n = s.len();
      for (int i = 0; i < n; i++) begin
        c = s[i];
        if (i == dir_tab[r].patch_at) c = dir_tab[r].patch_val;
        send_char(c, i == n - 1, dir_tab[r].chk, dir_tab[r].fill);
      end
    end

    used_items = 0;
    while (used_items < RandItems) begin
      if (!hold_done && used_items >= HoldAt) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      calm      = (used_items >= CalmFrom);
      tx_choppy = ($urandom_range(0, 2) != 0);
      // new phase now and then, same value allowed
      if ($urandom_range(0, 4) == 0) set_format($urandom_range(0, 1));
      build_text();
      foreach (txt[i]) send_char(txt[i], i == txt.size() - 1, CHK_MODEL, 8'h00);
    end

    char_if.valid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && bytes_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/utsb_pkg.sv
rtl/utsb_if.sv
rtl/uuid_text_to_swapped_binary.sv
bench/tb_uuid_text_to_swapped_binary.sv
